[rtl/core/rrw_pkg.sv]
`timescale 1ns / 1ps
package rrw_pkg;

  localparam int COORD_W   = 20;
  localparam int DIFF_W    = 21;
  localparam int D2_W      = 42;
  localparam int ROOT_W    = 21;
  localparam int SQREM_W   = 23;
  localparam int RAD_W     = 19;
  localparam int STR_W     = 8;
  localparam int ANIM_W    = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int QS_W      = 17;

  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int SINE_ADDR_BITS_DEF  = 10;

  localparam int COORD_MAX_I = 524287;
  localparam int COORD_MIN_I = -524288;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM     = 3'd4;

  localparam logic [29:0] TURNS_PER_RAD   = 30'd683565275;
  localparam logic [27:0] TURNS_PER_CYCLE = 28'd136713055;

  localparam logic [QS_W-1:0] Q_ONE = 17'd65536;
  localparam logic [12:0] SIN_C0  = 13'd5223;
  localparam logic [8:0]  SIN_C0M = 9'd307;
  localparam logic [15:0] SIN_C1  = 16'd42334;
  localparam logic [16:0] SIN_C2  = 17'd102944;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } rrw_point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] warped_x;
    logic signed [COORD_W-1:0] warped_y;
    logic                      was_moved;
  } rrw_warp_t;

endpackage

[rtl/core/rrw_stream_if.sv]
`timescale 1ns / 1ps
interface rrw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rrw_sqrt_cell.sv]
`timescale 1ns / 1ps
module rrw_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rrw_pkg::D2_W-1:0]     rad_in,
  input  logic [rrw_pkg::SQREM_W-1:0]  rem_in,
  input  logic [rrw_pkg::ROOT_W-1:0]   root_in,
  output logic [rrw_pkg::D2_W-1:0]     rad_out,
  output logic [rrw_pkg::SQREM_W-1:0]  rem_out,
  output logic [rrw_pkg::ROOT_W-1:0]   root_out
);
  import rrw_pkg::*;

  logic [SQREM_W+1:0] acc;
  logic [SQREM_W+1:0] trial;
  logic               fits;

  assign acc   = {rem_in, rad_in[D2_W-1 -: 2]};
  assign trial = (SQREM_W+2)'({root_in, 2'b01});
  assign fits  = acc >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[D2_W-3:0], 2'b00};
      if (fits) begin
        rem_out  <= SQREM_W'(acc - trial);
        root_out <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_out  <= SQREM_W'(acc);
        root_out <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/rrw_div_cell.sv]
`timescale 1ns / 1ps
module rrw_div_cell #(
  parameter int DW = 21,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  output logic [DW-1:0] rem_out,
  output logic [QW-1:0] low_out
);
  logic [DW:0] acc;
  logic        fits;

  assign acc  = {rem_in, low_in[QW-1]};
  assign fits = acc >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      if (fits) begin
        rem_out <= DW'(acc - {1'b0, den});
        low_out <= {low_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= DW'(acc);
        low_out <= {low_in[QW-2:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/rrw_qsine.sv]
`timescale 1ns / 1ps
module rrw_qsine (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rrw_pkg::QS_W-1:0] v_in,
  output logic [rrw_pkg::QS_W-1:0] f_out
);
  import rrw_pkg::*;

  logic [QS_W-1:0] v1, v2, v3, v4;
  logic [QS_W-1:0] w1, w2, w3;
  logic [12:0]     t0;
  logic [15:0]     t1;
  logic [16:0]     t2;

  logic [33:0] vv;
  logic [25:0] pa;
  logic [29:0] pb;
  logic [32:0] pc;
  logic [33:0] pe;

  assign vv = v_in * v_in;
  assign pa = w1 * SIN_C0M;
  assign pb = w2 * t0;
  assign pc = w3 * t1;
  assign pe = v4 * t2;

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= v_in;
      w1 <= vv[32:16];
      v2 <= v1;
      w2 <= w1;
      t0 <= SIN_C0 - 13'(pa[25:16]);
      v3 <= v2;
      w3 <= w2;
      t1 <= SIN_C1 - 16'(pb[29:16]);
      v4 <= v3;
      t2 <= SIN_C2 - pc[32:16];
      f_out <= pe[32:16];
    end
  end
endmodule

[rtl/core/radial_ripple_warp.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle; every stage advances together unless the result is held.
// Pipeline length comes mostly from the square root cells (21), the sine stages (5) and two
// dividers in sequence of COORD_FRAC_BITS+8 cells each.
// Reset: synchronous, active high; clears all stage valid bits and configuration registers.
module radial_ripple_warp #(
  parameter int COORD_FRAC_BITS      = rrw_pkg::COORD_FRAC_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = rrw_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rrw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrw_pkg::CFG_W-1:0]       cfg_data,
  rrw_stream_if.sink                      points,
  rrw_stream_if.source                    warps
);
  import rrw_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int A     = SINE_TABLE_ADDR_BITS;
  localparam int QW    = F + 8;
  localparam int USH   = 18 - A;
  localparam int NUMW  = 44;
  localparam int DEN1W = RAD_W + 16;
  localparam int PRODW = QW + DIFF_W;
  localparam int SW    = ((QW > COORD_W) ? QW : COORD_W) + 2;
  localparam int NSQ   = ROOT_W;
  localparam int NSIN  = 5;

  localparam logic signed [SW-1:0] SMAX = SW'(COORD_MAX_I);
  localparam logic signed [SW-1:0] SMIN = SW'(COORD_MIN_I);

  typedef struct packed {
    logic                      vld;
    logic                      moved;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [ROOT_W-1:0]         d;
    logic [RAD_W-1:0]          rmd;
    logic                      neg;
  } carry_t;

  logic signed [COORD_W-1:0] center_x, center_y;
  logic [RAD_W-1:0]          ripple_radius;
  logic signed [STR_W-1:0]   ripple_strength;
  logic [ANIM_W-1:0]         anim_cycle;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      ripple_radius   <= '0;
      ripple_strength <= '0;
      anim_cycle      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X: center_x        <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: center_y        <= cfg_data[COORD_W-1:0];
        REG_RADIUS:   ripple_radius   <= cfg_data[RAD_W-1:0];
        REG_STRENGTH: ripple_strength <= cfg_data[STR_W-1:0];
        REG_ANIM:     anim_cycle      <= cfg_data[ANIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv          = !warps.valid || warps.ready;
  assign points.ready = !rst && adv;

  // offsets
  carry_t c1, c1_next;
  always_comb begin
    c1_next       = '0;
    c1_next.vld   = points.valid;
    c1_next.px    = points.data.point_x;
    c1_next.py    = points.data.point_y;
    c1_next.dx    = DIFF_W'(points.data.point_x) - DIFF_W'(center_x);
    c1_next.dy    = DIFF_W'(points.data.point_y) - DIFF_W'(center_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
    end else if (adv) begin
      c1 <= c1_next;
    end
  end

  // squares
  carry_t                  c2;
  logic signed [D2_W-1:0]  sqx_next, sqy_next;
  logic [D2_W-1:0]         sqx, sqy;
  logic [2*RAD_W-1:0]      rr_next, rr;

  assign sqx_next = c1.dx * c1.dx;
  assign sqy_next = c1.dy * c1.dy;
  assign rr_next  = ripple_radius * ripple_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.vld <= 1'b0;
    end else if (adv) begin
      c2  <= c1;
      sqx <= sqx_next;
      sqy <= sqy_next;
      rr  <= rr_next;
    end
  end

  // squared distance and disc test
  carry_t          c3, c3_next;
  logic [D2_W-1:0] d2_next, d2;
  assign d2_next = sqx + sqy;

  always_comb begin
    c3_next       = c2;
    c3_next.moved = (d2_next != '0) && (d2_next <= D2_W'(rr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3.vld <= 1'b0;
    end else if (adv) begin
      c3 <= c3_next;
      d2 <= d2_next;
    end
  end

  // square root chain
  carry_t               cs   [0:NSQ];
  logic [D2_W-1:0]      rad  [0:NSQ];
  logic [SQREM_W-1:0]   srem [0:NSQ];
  logic [ROOT_W-1:0]    root [0:NSQ];

  assign cs[0]   = c3;
  assign rad[0]  = d2;
  assign srem[0] = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    rrw_sqrt_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .rad_in   (rad[k]),
      .rem_in   (srem[k]),
      .root_in  (root[k]),
      .rad_out  (rad[k+1]),
      .rem_out  (srem[k+1]),
      .root_out (root[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        cs[k+1].vld <= 1'b0;
      end else if (adv) begin
        cs[k+1] <= cs[k];
      end
    end
  end

  // phase products
  carry_t        p1, p1_next;
  logic [50:0]   ph_rad_next, ph_rad;
  logic [43:0]   ph_cyc_next, ph_cyc;

  assign ph_rad_next = root[NSQ] * TURNS_PER_RAD;
  assign ph_cyc_next = anim_cycle * TURNS_PER_CYCLE;

  always_comb begin
    p1_next     = cs[NSQ];
    p1_next.d   = root[NSQ];
    p1_next.rmd = ripple_radius - root[NSQ][RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.vld <= 1'b0;
    end else if (adv) begin
      p1     <= p1_next;
      ph_rad <= ph_rad_next;
      ph_cyc <= ph_cyc_next;
    end
  end

  // quadrant fold
  carry_t          p2, p2_next;
  logic [31:0]     phase;
  logic [A-1:0]    tab_addr;
  logic [1:0]      quad;
  logic [QS_W-1:0] u_lin, v_next, v_q;

  assign phase    = ph_rad[F +: 32] + ph_cyc[31:0];
  assign tab_addr = phase[31 -: A];
  assign quad     = tab_addr[A-1 -: 2];
  assign u_lin    = QS_W'(tab_addr[A-3:0]) << USH;
  assign v_next   = quad[0] ? (Q_ONE - u_lin) : u_lin;

  always_comb begin
    p2_next     = p1;
    p2_next.neg = quad[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2.vld <= 1'b0;
    end else if (adv) begin
      p2  <= p2_next;
      v_q <= v_next;
    end
  end

  // sine
  carry_t          cq [0:NSIN];
  logic [QS_W-1:0] sin_mag;

  rrw_qsine u_qsine (
    .clk   (clk),
    .en    (adv),
    .v_in  (v_q),
    .f_out (sin_mag)
  );

  assign cq[0] = p2;
  for (genvar k = 0; k < NSIN; k++) begin : g_sin
    always_ff @(posedge clk) begin
      if (rst) begin
        cq[k+1].vld <= 1'b0;
      end else if (adv) begin
        cq[k+1] <= cq[k];
      end
    end
  end

  // scale by strength and by remaining radius
  carry_t                   m1, m1_next, m2;
  logic [STR_W-1:0]         str_mag;
  logic [QS_W+STR_W-1:0]    m1p_next, m1p;
  logic [NUMW-1:0]          num_next, num_mag;

  assign str_mag  = ripple_strength[STR_W-1] ? STR_W'(-ripple_strength)
                                             : STR_W'(ripple_strength);
  assign m1p_next = sin_mag * str_mag;
  assign num_next = m1p * m1.rmd;

  always_comb begin
    m1_next     = cq[NSIN];
    m1_next.neg = cq[NSIN].neg ^ ripple_strength[STR_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.vld <= 1'b0;
      m2.vld <= 1'b0;
    end else if (adv) begin
      m1      <= m1_next;
      m1p     <= m1p_next;
      m2      <= m1;
      num_mag <= num_next;
    end
  end

  // displacement divider
  carry_t             cd   [0:QW];
  logic [DEN1W-1:0]   rem1 [0:QW];
  logic [QW-1:0]      low1 [0:QW];
  logic [DEN1W-1:0]   den1;
  logic [NUMW+F-1:0]  num_sh;

  assign den1    = {ripple_radius, 16'b0};
  assign num_sh  = num_mag << F;
  assign cd[0]   = m2;
  assign rem1[0] = DEN1W'(num_mag >> 8);
  assign low1[0] = num_sh[QW-1:0];

  for (genvar k = 0; k < QW; k++) begin : g_div1
    rrw_div_cell #(.DW(DEN1W), .QW(QW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .den     (den1),
      .rem_in  (rem1[k]),
      .low_in  (low1[k]),
      .rem_out (rem1[k+1]),
      .low_out (low1[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        cd[k+1].vld <= 1'b0;
      end else if (adv) begin
        cd[k+1] <= cd[k];
      end
    end
  end

  // project onto direction
  carry_t             x1;
  logic [DIFF_W-1:0]  adx, ady;
  logic [PRODW-1:0]   mx_next, my_next, mx, my;

  assign adx     = cd[QW].dx[DIFF_W-1] ? DIFF_W'(-cd[QW].dx) : DIFF_W'(cd[QW].dx);
  assign ady     = cd[QW].dy[DIFF_W-1] ? DIFF_W'(-cd[QW].dy) : DIFF_W'(cd[QW].dy);
  assign mx_next = low1[QW] * adx;
  assign my_next = low1[QW] * ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1.vld <= 1'b0;
    end else if (adv) begin
      x1 <= cd[QW];
      mx <= mx_next;
      my <= my_next;
    end
  end

  // per-axis dividers by distance
  carry_t             cx   [0:QW];
  logic [ROOT_W-1:0]  remx [0:QW];
  logic [ROOT_W-1:0]  remy [0:QW];
  logic [QW-1:0]      lowx [0:QW];
  logic [QW-1:0]      lowy [0:QW];

  assign cx[0]   = x1;
  assign remx[0] = mx[PRODW-1:QW];
  assign remy[0] = my[PRODW-1:QW];
  assign lowx[0] = mx[QW-1:0];
  assign lowy[0] = my[QW-1:0];

  for (genvar k = 0; k < QW; k++) begin : g_div2
    rrw_div_cell #(.DW(ROOT_W), .QW(QW)) u_cell_x (
      .clk     (clk),
      .en      (adv),
      .den     (cx[k].d),
      .rem_in  (remx[k]),
      .low_in  (lowx[k]),
      .rem_out (remx[k+1]),
      .low_out (lowx[k+1])
    );
    rrw_div_cell #(.DW(ROOT_W), .QW(QW)) u_cell_y (
      .clk     (clk),
      .en      (adv),
      .den     (cx[k].d),
      .rem_in  (remy[k]),
      .low_in  (lowy[k]),
      .rem_out (remy[k+1]),
      .low_out (lowy[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        cx[k+1].vld <= 1'b0;
      end else if (adv) begin
        cx[k+1] <= cx[k];
      end
    end
  end

  // add and saturate, or pass unmoved points through
  carry_t                 cfin;
  logic signed [SW-1:0]   dlx, dly, sumx, sumy;
  logic signed [COORD_W-1:0] outx, outy;

  assign cfin = cx[QW];
  assign dlx  = SW'(lowx[QW]);
  assign dly  = SW'(lowy[QW]);
  assign sumx = SW'(cfin.px) + ((cfin.neg ^ cfin.dx[DIFF_W-1]) ? -dlx : dlx);
  assign sumy = SW'(cfin.py) + ((cfin.neg ^ cfin.dy[DIFF_W-1]) ? -dly : dly);

  always_comb begin
    if (!cfin.moved) begin
      outx = cfin.px;
      outy = cfin.py;
    end else begin
      outx = (sumx > SMAX) ? COORD_W'(SMAX) : (sumx < SMIN) ? COORD_W'(SMIN)
                                                             : COORD_W'(sumx);
      outy = (sumy > SMAX) ? COORD_W'(SMAX) : (sumy < SMIN) ? COORD_W'(SMIN)
                                                             : COORD_W'(sumy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warps.valid <= 1'b0;
    end else if (adv) begin
      warps.valid <= cfin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      warps.data.warped_x  <= outx;
      warps.data.warped_y  <= outy;
      warps.data.was_moved <= cfin.moved;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !warps.valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !warps.valid |-> points.ready)
    else $error("input stalled with empty output");

  a_root_in_radius: assert property (@(posedge clk) disable iff (rst)
    (cs[NSQ].vld && cs[NSQ].moved) |-> (root[NSQ][ROOT_W-1:RAD_W] == '0))
    else $error("root beyond radius range");

  a_div1_rem: assert property (@(posedge clk) disable iff (rst)
    (cd[QW].vld && cd[QW].moved) |-> (rem1[QW] < den1))
    else $error("displacement remainder not below divisor");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (adv && cfin.vld && !cfin.moved) |=>
      (warps.data.warped_x == $past(cfin.px) && warps.data.warped_y == $past(cfin.py)))
    else $error("unmoved item changed");

endmodule
